// ----- rtl/kdrm_pkg.sv -----
// Package for the k-way descending run merge unit.
// Holds lane counts, field widths, the phase type and the head compare helper.
// No dependencies.
package kdrm_pkg;

    localparam int LANES     = 8;
    localparam int SLOTS     = (LANES < 8) ? LANES : 8;
    localparam int TREE_W    = 8;
    localparam int KEY_W     = 32;
    localparam int HANDLE_W  = 32;
    localparam int LANE_W    = 3;
    localparam int CNT_W     = 4;
    localparam int MASK_W    = 8;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 80;

    localparam logic [CNT_W-1:0] LANES_RESET = CNT_W'(2);
    localparam logic [CNT_W-1:0] LANES_MIN   = CNT_W'(2);
    localparam logic [CNT_W-1:0] LANES_MAX   = CNT_W'(SLOTS);

    typedef enum logic [1:0] {
        PH_LOAD  = 2'b01,
        PH_MERGE = 2'b10
    } phase_t;

    typedef struct packed {
        logic              vld;
        logic [KEY_W-1:0]  key;
        logic [LANE_W-1:0] idx;
    } node_t;

    // larger key wins, ties go to the higher lane (hi)
    function automatic node_t pick_head(input node_t lo, input node_t hi);
        node_t r;
        r = lo;
        if (hi.vld && (!lo.vld || !($signed(lo.key) > $signed(hi.key)))) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// ----- rtl/kway_descending_run_merge_unit.sv -----
// Top level of the k-way descending run merge unit: input register, head store,
// compare tree and result register. Depends on kdrm_pkg.
//
// A result is registered from the item in the input register; in the load phase
// a result is only emitted once every lane in use has loaded its head.
// Throughput: one input item per cycle while the result register is free; the head
// update and the eight-leaf compare tree are combinational between both registers.
// Reset (aresetn low, synchronous): lane count 2, load phase, all lanes active, no
// heads held, both registers empty. A config write re-arms all but the registers.
module kway_descending_run_merge_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [kdrm_pkg::CNT_W-1:0]      cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // lane [2:0], in_key [34:3], record_handle [66:35], zero [71:67]
    input  logic [kdrm_pkg::S_TDATA_W-1:0]  s_tdata,
    // present [0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_key [31:0], out_handle [63:32], source_lane [66:64],
    // target_file [69:67], lanes_active [77:70], zero [79:78]
    output logic [kdrm_pkg::M_TDATA_W-1:0]  m_tdata,
    // kind [0]
    output logic                            m_tuser
);
    import kdrm_pkg::*;

    logic [CNT_W-1:0]    lanes_reg;
    logic [CNT_W-1:0]    lane_n;

    logic                in_valid_reg, in_valid_next;
    logic                in_present_reg;
    logic [KEY_W-1:0]    in_key_reg;
    logic [HANDLE_W-1:0] in_handle_reg;

    logic [KEY_W-1:0]    head_key_reg    [SLOTS];
    logic [KEY_W-1:0]    head_key_next   [SLOTS];
    logic [HANDLE_W-1:0] head_handle_reg [SLOTS];
    logic [HANDLE_W-1:0] head_handle_next[SLOTS];
    logic [SLOTS-1:0]    head_valid_reg, head_valid_next;
    logic [MASK_W-1:0]   active_mask_reg, active_mask_next;
    logic [CNT_W-1:0]    load_count_reg, load_count_next;
    logic [KEY_W-1:0]    popped_key_reg, popped_key_next;
    logic [LANE_W-1:0]   popped_lane_reg, popped_lane_next;
    logic [LANE_W-1:0]   target_reg, target_next;
    phase_t              phase_reg, phase_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_load;
    logic                out_kind_next, out_kind_reg;
    logic [KEY_W-1:0]    out_key_next, out_key_reg;
    logic [HANDLE_W-1:0] out_handle_next, out_handle_reg;
    logic [LANE_W-1:0]   out_lane_next, out_lane_reg;
    logic [LANE_W-1:0]   out_target_next, out_target_reg;
    logic [MASK_W-1:0]   out_mask_next, out_mask_reg;

    logic                out_free;
    logic                s_accept;
    logic                step;

    always_comb begin
        if (lanes_reg < LANES_MIN) begin
            lane_n = LANES_MIN;
        end else if (lanes_reg > LANES_MAX) begin
            lane_n = LANES_MAX;
        end else begin
            lane_n = lanes_reg;
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign step     = in_valid_reg && out_free;

    assign in_valid_next = s_accept ? 1'b1 : (step ? 1'b0 : in_valid_reg);

    always_comb begin
        node_t             node [2*TREE_W-1];
        logic [LANE_W-1:0] slot;
        logic              loading;
        logic              write_head;
        logic              emit;
        logic [CNT_W-1:0]  count_inc;
        logic [CNT_W-1:0]  target_inc;

        head_key_next    = head_key_reg;
        head_handle_next = head_handle_reg;
        head_valid_next  = head_valid_reg;
        active_mask_next = active_mask_reg;
        load_count_next  = load_count_reg;
        popped_key_next  = popped_key_reg;
        popped_lane_next = popped_lane_reg;
        target_next      = target_reg;
        phase_next       = phase_reg;

        loading    = (phase_reg == PH_LOAD);
        slot       = loading ? load_count_reg[LANE_W-1:0] : popped_lane_reg;
        count_inc  = load_count_reg + CNT_W'(1);
        target_inc = {1'b0, target_reg} + CNT_W'(1);
        write_head = in_present_reg &&
                     (loading || !($signed(in_key_reg) > $signed(popped_key_reg)));
        emit       = !loading || (count_inc == lane_n);

        if (step) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (slot == LANE_W'(i)) begin
                    if (write_head) begin
                        head_key_next[i]    = in_key_reg;
                        head_handle_next[i] = in_handle_reg;
                        head_valid_next[i]  = 1'b1;
                    end else if (loading) begin
                        head_valid_next[i]  = 1'b0;
                    end
                end
            end
            if (!in_present_reg) begin
                active_mask_next[slot] = 1'b0;
            end
            if (loading) begin
                load_count_next = count_inc;
            end
        end

        for (int j = 0; j < TREE_W; j++) begin
            node[TREE_W-1+j].vld = 1'b0;
            node[TREE_W-1+j].key = '0;
            node[TREE_W-1+j].idx = LANE_W'(j);
            if (j < SLOTS) begin
                node[TREE_W-1+j].vld = head_valid_next[j] && (CNT_W'(j) < lane_n);
                node[TREE_W-1+j].key = head_key_next[j];
            end
        end
        for (int k = TREE_W - 2; k >= 0; k--) begin
            node[k] = pick_head(node[2*k+1], node[2*k+2]);
        end

        out_load        = step && emit;
        out_kind_next   = 1'b1;
        out_key_next    = '0;
        out_handle_next = '0;
        out_lane_next   = '0;
        out_target_next = target_reg;
        out_mask_next   = active_mask_next;

        if (out_load) begin
            if (node[0].vld) begin
                out_kind_next = 1'b0;
                out_key_next  = node[0].key;
                out_lane_next = node[0].idx;
                for (int i = 0; i < SLOTS; i++) begin
                    if (node[0].idx == LANE_W'(i)) begin
                        out_handle_next    = head_handle_next[i];
                        head_valid_next[i] = 1'b0;
                    end
                end
                popped_key_next  = node[0].key;
                popped_lane_next = node[0].idx;
                phase_next       = PH_MERGE;
            end else begin
                target_next     = (target_inc == lane_n) ? '0 : target_inc[LANE_W-1:0];
                load_count_next = '0;
                phase_next      = PH_LOAD;
            end
        end

        out_valid_next = out_load || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_present_reg <= s_tuser;
            in_key_reg     <= s_tdata[34:3];
            in_handle_reg  <= s_tdata[66:35];
        end
        if (out_load) begin
            out_kind_reg   <= out_kind_next;
            out_key_reg    <= out_key_next;
            out_handle_reg <= out_handle_next;
            out_lane_reg   <= out_lane_next;
            out_target_reg <= out_target_next;
            out_mask_reg   <= out_mask_next;
        end
        head_key_reg    <= head_key_next;
        head_handle_reg <= head_handle_next;
        popped_key_reg  <= popped_key_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lanes_reg       <= LANES_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            head_valid_reg  <= '0;
            active_mask_reg <= '1;
            load_count_reg  <= '0;
            popped_lane_reg <= '0;
            target_reg      <= '0;
            phase_reg       <= PH_LOAD;
        end else if (cfg_wr_en) begin
            lanes_reg       <= cfg_wr_data;
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            head_valid_reg  <= '0;
            active_mask_reg <= '1;
            load_count_reg  <= '0;
            popped_lane_reg <= '0;
            target_reg      <= '0;
            phase_reg       <= PH_LOAD;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            head_valid_reg  <= head_valid_next;
            active_mask_reg <= active_mask_next;
            load_count_reg  <= load_count_next;
            popped_lane_reg <= popped_lane_next;
            target_reg      <= target_next;
            phase_reg       <= phase_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_mask_reg, out_target_reg, out_lane_reg,
                       out_handle_reg, out_key_reg};

    a_load_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_LOAD |-> load_count_reg < lane_n)
        else $error("load count reached the lane count in the load phase");

    a_popped_lane_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_MERGE |-> {1'b0, popped_lane_reg} < lane_n)
        else $error("popped lane outside the lanes in use");

    a_heads_within_lanes: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid_reg >> lane_n) == '0)
        else $error("head held on a lane beyond the lanes in use");

    a_mask_only_clears: assert property (@(posedge aclk)
        aresetn && $past(aresetn) && !$past(cfg_wr_en)
        |-> (active_mask_reg & ~$past(active_mask_reg)) == '0)
        else $error("active mask bit set again without a re-arm");

    a_result_needs_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> in_valid_reg && out_free)
        else $error("result loaded without an input item in the register");

endmodule
